[rtl/softmax_cross_entropy_loss_grad_assert.svh]
// Assertion macros for the cross-entropy loss block.
`ifndef SOFTMAX_CROSS_ENTROPY_LOSS_GRAD_ASSERT_SVH
`define SOFTMAX_CROSS_ENTROPY_LOSS_GRAD_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SCE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/sce_pkg.sv]
// Shared types and constants for the cross-entropy loss block.
package sce_pkg;
    localparam int DEF_MAX_CLASSES = 1024;
    localparam int DEF_MAX_BATCH   = 256;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [19:0] MEAN_MAX = 20'hFFFFF;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOG  = 6'b000010,
        ST_SCL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MEAN = 6'b010000,
        ST_OUT  = 6'b100000
    } sce_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic log_step;
        logic scale;
        logic div_step;
        logic mean_start;
        logic mean_step;
        logic commit;
    } sce_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic last;
        logic log_done;
        logic div_done;
        logic mean_done;
    } sce_sts_t;
endpackage

[rtl/softmax_cross_entropy_loss_grad.sv]
// Top level of the categorical cross-entropy loss and gradient block.
//
// Input channel: in_valid/in_stall carry one softmax element (probability,
// Q1.16), the sample's true_class and batch_end. Output channel:
// out_valid/out_stall carry one result transaction per input transaction:
// gradient (Q16.8), mean_loss (Q4.16, nonzero only with loss_valid),
// loss_valid and label_error.
// class_count is written through cfg_we/cfg_data while the block is idle;
// the user must keep to that, as the block does not enforce it. A non-label
// element is captured, passes LOG and MEAN without work and commits its
// result to OUT. The label element adds 16 log2 squaring steps, one scale
// step and 25 restoring divider steps for the gradient; a batch-end element
// adds the mean divider steps. One transaction is in flight at a time, so
// the rate is set by those iterative units in the shared datapath.
// Reset clears counters, the loss sum and sets class_count to 10.
// A stalled result holds its value; no new input is accepted meanwhile.
module softmax_cross_entropy_loss_grad
    import sce_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int MAX_BATCH   = DEF_MAX_BATCH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [16:0]        probability,
    input  logic [9:0]         true_class,
    input  logic               batch_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [24:0] gradient,
    output logic [19:0]        mean_loss,
    output logic               loss_valid,
    output logic               label_error
);
    sce_cmd_t cmd;
    sce_sts_t sts;

    sce_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    sce_datapath #(.MAX_CLASSES(MAX_CLASSES), .MAX_BATCH(MAX_BATCH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .probability(probability), .true_class(true_class), .batch_end(batch_end),
        .cmd(cmd), .sts(sts), .gradient(gradient), .mean_loss(mean_loss),
        .loss_valid(loss_valid), .label_error(label_error)
    );
endmodule

[rtl/sce_ctrl.sv]
// Controller sequencing one transaction through the datapath.
module sce_ctrl
    import sce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  sce_sts_t sts,
    output sce_cmd_t cmd
);
    sce_state_t state_reg, state_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (!sts.hit)
                    state_next = ST_MEAN;
                else
                begin
                    cmd.log_step = 1'b1;
                    if (sts.log_done)
                        state_next = ST_SCL;
                end
            end
            ST_SCL:
            begin
                cmd.scale = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                if (!sts.last)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.mean_step = 1'b1;
                    if (sts.mean_done)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.mean_start = cmd.capture;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`include "softmax_cross_entropy_loss_grad_assert.svh"
    `SCE_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_reg))
    `SCE_ASSERT_NXT(a_cap, state_reg == ST_IDLE && in_valid, state_reg == ST_LOG)
    `SCE_ASSERT_NXT(a_hold, state_reg == ST_OUT && out_stall, state_reg == ST_OUT)
endmodule

[rtl/sce_datapath.sv]
// Datapath: counters, loss accumulator, log, reciprocal and mean units.
module sce_datapath
    import sce_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int MAX_BATCH   = DEF_MAX_BATCH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_data,
    input  logic [16:0]        probability,
    input  logic [9:0]         true_class,
    input  logic               batch_end,
    input  sce_cmd_t           cmd,
    output sce_sts_t           sts,
    output logic signed [24:0] gradient,
    output logic [19:0]        mean_loss,
    output logic               loss_valid,
    output logic               label_error
);
    localparam int PW = $clog2(MAX_CLASSES);
    localparam int TW = $clog2(MAX_BATCH + 1);

    logic [10:0]   class_count_reg;
    logic [PW-1:0] pos_reg;
    logic [TW-1:0] tally_reg;
    logic [31:0]   sum_reg;

    logic [16:0] pc_reg;
    logic        hit_reg, last_reg, err_reg;
    logic        wrap_reg;
    logic [4:0]  n_reg;
    logic [31:0] m_reg;
    logic [4:0]  lcnt_reg;
    logic [15:0] frac_reg;
    logic [31:0] term_reg;
    logic [24:0] dnum_reg;
    logic [24:0] dq_reg;
    logic [17:0] drem_reg;
    logic [4:0]  dcnt_reg;
    logic [32:0] mrem_reg;
    logic [31:0] mq_reg;
    logic [5:0]  mcnt_reg;
    logic [TW-1:0] div_s_reg;

    // effective class count
    logic [16:0] eff;
    always_comb
    begin
        if (class_count_reg == 11'd0)
            eff = 17'd1;
        else if ({6'd0, class_count_reg} > 17'(MAX_CLASSES))
            eff = 17'(MAX_CLASSES);
        else
            eff = {6'd0, class_count_reg};
    end

    logic in_err, in_hit;
    assign in_err = {7'd0, true_class} >= eff;
    assign in_hit = !in_err && ({7'd0, true_class} == 17'(pos_reg));

    logic [16:0] pcl;
    assign pcl = (probability == 17'd0) ? 17'd1 :
                 (probability > 17'd65536) ? 17'd65536 : probability;

    logic [4:0] lz;
    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i <= 16; i++)
            if (pcl[i])
                lz = 5'(i);
    end

    // log2 squaring step
    logic [63:0] sq;
    assign sq = 64'(m_reg) * 64'(m_reg);
    logic [33:0] msq;
    assign msq = sq[63:30];

    // ln scaling
    logic [20:0] l2;
    logic [20:0] neg;
    logic [63:0] prod;
    assign l2 = {n_reg, 16'd0} + {5'd0, frac_reg};
    assign neg = 21'(16 * 65536) - l2;
    assign prod = 64'(neg) * 64'(LN2_Q32) + 64'h80000000;

    // divider step for gradient
    logic [17:0] dtr;
    assign dtr = {drem_reg[16:0], dnum_reg[24]};
    logic [32:0] mtr;
    assign mtr = {mrem_reg[31:0], mq_reg[31]};

    logic [32:0] sum_sat;
    assign sum_sat = {1'b0, sum_reg} + {1'b0, term_reg};

    // sum including this transaction's term (term is zero off the label)
    logic [31:0] sum_acc;
    assign sum_acc = sum_sat[32] ? 32'hFFFFFFFF : sum_sat[31:0];

    logic [TW:0] samples;
    assign samples = {1'b0, tally_reg} + 1'b1;

    // mean divisor and rounded dividend
    logic [TW-1:0] mdiv;
    logic [32:0]   mdvd;
    assign mdiv = (samples > (TW+1)'(MAX_BATCH)) ? TW'(MAX_BATCH) : samples[TW-1:0];
    assign mdvd = {1'b0, sum_acc} + 33'(mdiv >> 1);

    assign sts.hit       = hit_reg;
    assign sts.last      = last_reg;
    assign sts.log_done  = (lcnt_reg == 5'd15);
    assign sts.div_done  = (dcnt_reg == 5'd24);
    assign sts.mean_done = (mcnt_reg == 6'd31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= 11'd10;
            pos_reg   <= '0;
            tally_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                class_count_reg <= cfg_data;
            if (cmd.commit)
            begin
                if (last_reg)
                begin
                    pos_reg   <= '0;
                    tally_reg <= '0;
                    sum_reg   <= '0;
                end
                else
                begin
                    if (hit_reg)
                        sum_reg <= sum_acc;
                    if (wrap_reg)
                    begin
                        pos_reg <= '0;
                        if (tally_reg < TW'(MAX_BATCH))
                            tally_reg <= tally_reg + 1'b1;
                    end
                    else
                        pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pc_reg   <= pcl;
            hit_reg  <= in_hit;
            err_reg  <= in_err;
            last_reg <= batch_end;
            wrap_reg <= (17'(pos_reg) + 17'd1) >= eff;
            n_reg    <= lz;
            m_reg    <= 32'({15'd0, pcl} << (5'd30 - lz));
            lcnt_reg <= 5'd0;
            frac_reg <= 16'd0;
            term_reg <= 32'd0;
            dcnt_reg <= 5'd0;
            dnum_reg <= 25'(33'h1000000 + 33'(pcl >> 1));
            drem_reg <= '0;
            dq_reg   <= '0;
        end
        if (cmd.log_step)
        begin
            lcnt_reg <= lcnt_reg + 1'b1;
            if (msq >= 34'h80000000)
            begin
                m_reg <= msq[32:1];
                frac_reg <= frac_reg | (16'h8000 >> lcnt_reg[3:0]);
            end
            else
                m_reg <= msq[31:0];
        end
        if (cmd.scale)
            term_reg <= prod[63:32];
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
            dnum_reg <= {dnum_reg[23:0], 1'b0};
            if (dtr >= {1'b0, pc_reg})
            begin
                drem_reg <= dtr - {1'b0, pc_reg};
                dq_reg <= {dq_reg[23:0], 1'b1};
            end
            else
            begin
                drem_reg <= dtr;
                dq_reg <= {dq_reg[23:0], 1'b0};
            end
        end
        if (cmd.mean_start)
        begin
            mcnt_reg <= 6'd0;
            mrem_reg <= '0;
            mq_reg <= '0;
            div_s_reg <= '0;
        end
        if (cmd.mean_step)
        begin
            if (mcnt_reg == 6'd0 && div_s_reg == '0)
            begin
                // load dividend on first step
                div_s_reg <= mdiv;
                mq_reg    <= mdvd[31:0];
                mrem_reg  <= {32'd0, mdvd[32]};
            end
            else
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
                if (mtr >= 33'(div_s_reg))
                begin
                    mrem_reg <= mtr - 33'(div_s_reg);
                    mq_reg <= {mq_reg[30:0], 1'b1};
                end
                else
                begin
                    mrem_reg <= mtr;
                    mq_reg <= {mq_reg[30:0], 1'b0};
                end
            end
        end
    end

    // 33-bit dividend: bit 32 is preloaded into mrem; final quotient uses step 32 below
    logic [32:0] mfin;
    logic [31:0] mq_fin;
    assign mfin = {mrem_reg[31:0], mq_reg[31]};
    assign mq_fin = (mfin >= 33'(div_s_reg)) ? {mq_reg[30:0], 1'b1} : {mq_reg[30:0], 1'b0};

    logic [19:0] mean_q;
    assign mean_q = (mq_fin > 32'(MEAN_MAX)) ? MEAN_MAX : mq_fin[19:0];

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            gradient    <= hit_reg ? -$signed(dq_reg) : 25'sd0;
            mean_loss   <= last_reg ? mean_q : 20'd0;
            loss_valid  <= last_reg;
            label_error <= err_reg;
        end
    end
endmodule

[dv/tb_softmax_cross_entropy_loss_grad.sv]
// Testbench for the cross-entropy loss and gradient block: directed and random streams.
`timescale 1ns / 100ps

module tb_softmax_cross_entropy_loss_grad;
    import sce_pkg::*;

    // Expected result of one transaction.
    typedef struct {
        logic signed [24:0] gradient;
        logic [19:0]        mean_loss;
        logic               loss_valid;
        logic               label_error;
    } loss_result_t;

    localparam int MAXC = DEF_MAX_CLASSES;
    localparam int MAXB = DEF_MAX_BATCH;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [10:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [16:0] probability = '0;
    logic [9:0] true_class = '0;
    logic batch_end = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [24:0] gradient;
    logic [19:0] mean_loss;
    logic loss_valid;
    logic label_error;

    // Predictor state, mirrors the block's counters and register.
    logic [10:0] class_count_q;
    int unsigned position_q;
    int unsigned tally_q;
    logic [31:0] sum_q;

    loss_result_t expected_q[$];
    int mismatches = 0;
    int idle_pct = 38;        // shared idle rate; 0 gives a stretch with no idling
    int hold_cycles = 0;      // long receiver hold-off, counted in its own process

    always #5 clk = ~clk;

    softmax_cross_entropy_loss_grad dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .probability(probability), .true_class(true_class), .batch_end(batch_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .gradient(gradient), .mean_loss(mean_loss),
        .loss_valid(loss_valid), .label_error(label_error)
    );

    // -ln(pc) in Q4.16 via a squaring log2 loop.
    function automatic logic [31:0] neg_ln(input logic [16:0] pc);
        int unsigned n;
        logic [63:0] m;
        logic [31:0] frac;
        logic [31:0] l2;
        logic [63:0] prod;
        n = 0;
        frac = 0;
        while (n < 16 && (pc >> (n + 1)) != 0)
            n++;
        m = 64'(pc) << (30 - n);
        for (int i = 1; i <= 16; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | (32'd1 << (16 - i));
            end
        end
        l2 = n * 65536 + frac;
        prod = 64'(32'd1048576 - l2) * 64'(LN2_Q32) + (64'd1 << 31);
        return prod[63:32];
    endfunction

    // Computes the expected result of one element and advances the model state.
    function automatic loss_result_t predict_loss(input logic [16:0] p,
                                                  input logic [9:0] label,
                                                  input logic last);
        loss_result_t r;
        int unsigned eff;
        logic [16:0] pc;
        logic [32:0] s;
        logic [63:0] mag;
        logic [63:0] samples;
        logic [63:0] mean;
        eff = class_count_q;
        if (eff < 1) eff = 1;
        if (eff > MAXC) eff = MAXC;
        r.gradient = '0;
        r.mean_loss = '0;
        r.loss_valid = last;
        r.label_error = (label >= eff);
        if (!r.label_error && position_q == label)
        begin
            pc = p;
            if (pc < 1) pc = 1;
            if (pc > 65536) pc = 65536;
            s = 33'(sum_q) + 33'(neg_ln(pc));
            sum_q = s[32] ? 32'hFFFFFFFF : s[31:0];
            mag = ((64'd1 << 24) + 64'(pc >> 1)) / 64'(pc);
            r.gradient = 25'(-mag);
        end
        if (last)
        begin
            samples = tally_q + 1;
            if (samples > MAXB) samples = MAXB;
            mean = (64'(sum_q) + samples / 2) / samples;
            if (mean > 64'(MEAN_MAX)) mean = 64'(MEAN_MAX);
            r.mean_loss = mean[19:0];
            position_q = 0;
            tally_q = 0;
            sum_q = 0;
        end
        else if (position_q + 1 >= eff)
        begin
            position_q = 0;
            if (tally_q < MAXB) tally_q++;
        end
        else
            position_q++;
        return r;
    endfunction

    // Sends one transaction; prediction happens on acceptance. Valid stays
    // high on return so back-to-back calls need no extra edge.
    task automatic send_element(input logic [16:0] p, input logic [9:0] label,
                                input logic last);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        probability <= p;
        true_class <= label;
        batch_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(predict_loss(p, label, last));
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Register write while idle.
    task automatic write_class_count(input logic [10:0] value);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        class_count_q = value;
    endtask

    // Receiver: random stall at the falling edge, checks at the rising edge.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        loss_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: grad=%0d", gradient);
            end
            else
            begin
                e = expected_q.pop_front();
                if (gradient !== e.gradient || mean_loss !== e.mean_loss ||
                    loss_valid !== e.loss_valid || label_error !== e.label_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp grad=%0d mean=%0d lv=%0b le=%0b, got grad=%0d mean=%0d lv=%0b le=%0b",
                                 e.gradient, e.mean_loss, e.loss_valid, e.label_error,
                                 gradient, mean_loss, loss_valid, label_error);
                end
            end
        end
    end

    // Random sample with a label drawn mostly in range.
    task automatic send_sample(input int unsigned classes, input logic last_sample);
        logic [9:0] label;
        logic [16:0] p;
        label = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(classes - 1));
        for (int unsigned c = 0; c < classes; c++)
        begin
            case ($urandom_range(5))
                0: p = 17'($urandom_range(3));
                1: p = 17'($urandom_range(131071, 65536));
                default: p = 17'($urandom_range(65536));
            endcase
            send_element(p, label, last_sample && (c == classes - 1));
        end
    endtask

    task automatic test_reset_count();
        // Default of ten classes, extreme probabilities at the label.
        send_element(17'd0, 10'd0, 1'b0);
        for (int i = 1; i < 10; i++)
            send_element(17'd65536, 10'd0, 1'b0);
        send_element(17'd1, 10'd9, 1'b0);
        for (int i = 1; i < 9; i++)
            send_element(17'h1FFFF, 10'd9, 1'b0);
        send_element(17'h1FFFF, 10'd9, 1'b1);
    endtask

    task automatic test_extremes();
        write_class_count(11'd0);          // acts as one class
        send_element(17'd1, 10'd0, 1'b0);
        send_element(17'd32768, 10'd1023, 1'b0);   // label error
        send_element(17'd65535, 10'd0, 1'b1);
        write_class_count(11'h7FF);        // clamps to the maximum
        send_element(17'd12345, 10'd0, 1'b0);
        send_element(17'd2, 10'd1, 1'b1);
        write_class_count(11'd1024);
        send_element(17'd100, 10'd0, 1'b1);
    endtask

    task automatic test_lowered_count();
        // Position beyond a lowered count ends the sample.
        write_class_count(11'd6);
        for (int i = 0; i < 4; i++)
            send_element(17'd40000, 10'd3, 1'b0);
        write_class_count(11'd2);
        send_element(17'd50000, 10'd1, 1'b0);
        send_element(17'd50000, 10'd0, 1'b1);
    endtask

    task automatic test_saturation();
        // One class, near-zero probability: drives the sample tally to saturation.
        write_class_count(11'd1);
        idle_pct = 0;
        for (int i = 0; i < 300; i++)
            send_element(17'd1, 10'd0, i == 299);
        idle_pct = 38;
    endtask

    task automatic test_random();
        int unsigned classes;
        int unsigned samples;
        for (int phase = 0; phase < 12; phase++)
        begin
            classes = (phase == 5) ? 64 : $urandom_range(8, 1);
            write_class_count(11'(classes));
            if (phase == 3) idle_pct = 0;
            if (phase == 4) idle_pct = 38;
            if (phase == 6)
            begin
                @(negedge clk);
                hold_cycles <= 400;
            end
            samples = (phase == 5) ? 2 : $urandom_range(14, 4);
            for (int s = 0; s < samples; s++)
                send_sample(classes, s == samples - 1);
            if ($urandom_range(3) == 0)
                send_element(17'($urandom), 10'($urandom), 1'b1);   // stray element
            if (phase == 8)
                wait_drain();                                       // sender pause
        end
    endtask

    initial
    begin
        class_count_q = 11'd10;
        position_q = 0;
        tally_q = 0;
        sum_q = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_count();
        test_extremes();
        test_lowered_count();
        test_saturation();
        test_random();
        wait_drain();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_softmax_cross_entropy_loss_grad: PASS");
        else
            $display("tb_softmax_cross_entropy_loss_grad: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_softmax_cross_entropy_loss_grad: FAIL");
        $finish;
    end
endmodule

[softmax_cross_entropy_loss_grad.f]
+incdir+rtl
rtl/sce_pkg.sv
rtl/sce_ctrl.sv
rtl/sce_datapath.sv
rtl/softmax_cross_entropy_loss_grad.sv
dv/tb_softmax_cross_entropy_loss_grad.sv
